// ===== sv/stt_pkg.sv =====
`default_nettype none
package stt_pkg;

   localparam int POS_W  = 32;
   localparam int LEN_W  = 16;
   localparam int KIND_W = 7;
   localparam int ERR_W  = 2;
   localparam int KW_DEPTH = 9;
   localparam int KW_COUNT = 34;
   localparam int KW_BITS  = 8 * KW_DEPTH;

   localparam logic [KIND_W-1:0] KIND_PUNCT  = KIND_W'(34);
   localparam logic [KIND_W-1:0] KIND_NUMBER = KIND_W'(42);
   localparam logic [KIND_W-1:0] KIND_SYMBOL = KIND_W'(43);
   localparam logic [KIND_W-1:0] KIND_KW     = KIND_W'(44);
   localparam logic [KIND_W-1:0] KIND_TILDE  = KIND_W'(10);
   localparam logic [KIND_W-1:0] KIND_ERROR  = KIND_W'(0);

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_CHAR  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_BLOCK = 2'd2;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      OP_NE, OP_NOT, OP_ANDAND, OP_ANDEQ, OP_AND, OP_OROR, OP_OREQ, OP_OR, OP_XOREQ, OP_XOR,
      OP_TILDE, OP_ADDEQ, OP_ADD, OP_SUBEQ, OP_ARROW, OP_SUB, OP_POWEQ, OP_POW, OP_MULEQ,
      OP_MUL, OP_DIVEQ, OP_DIV, OP_MODEQ, OP_MOD, OP_EQEQ, OP_ASSIGN, OP_SHLEQ, OP_SHL, OP_LE,
      OP_LT, OP_SHREQ, OP_SHR, OP_GE, OP_GT
   } op_kind_type;

   typedef enum logic [4:0] {
      MODE_IDLE, MODE_BANG, MODE_AMP, MODE_PIPE, MODE_CARET, MODE_PLUS, MODE_MINUS,
      MODE_STAR, MODE_STAR2, MODE_SLASH, MODE_PERCENT, MODE_EQUAL, MODE_LT, MODE_LT2,
      MODE_GT, MODE_GT2, MODE_NUMBER, MODE_IDENT, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR
   } lex_mode_type;

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [POS_W-1:0]  token_start;
      logic [LEN_W-1:0]  token_length;
      logic [ERR_W-1:0]  error_code;
      logic              last_of_run;
   } rsp_item_type;

   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      "as", "bool", "break", "const", "continue", "do", "else", "explicit",
      "f32", "f64", "false", "func", "i16", "i32", "i64", "i8", "if",
      "inherits", "interface", "isize", "let", "namespace", "return", "self",
      "struct", "true", "type", "u16", "u32", "u64", "u8", "usize", "void",
      "while"};

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd2, 4'd4, 4'd5, 4'd5, 4'd8, 4'd2, 4'd4, 4'd8,
      4'd3, 4'd3, 4'd5, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2,
      4'd8, 4'd9, 4'd5, 4'd3, 4'd9, 4'd6, 4'd4,
      4'd6, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd5, 4'd4,
      4'd5};

   // identifier chars are held first char in the top byte
   function automatic logic [KIND_W-1:0] ident_kind(input logic [KW_BITS-1:0] chars,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic overflow);
      logic [KIND_W-1:0] kind;
      logic [KW_BITS-1:0] mask;
      logic [KW_BITS-1:0] word;
      kind = KIND_SYMBOL;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         mask = {KW_BITS{1'b1}} << (8 * (KW_DEPTH - int'(KW_LEN[k])));
         word = KW_TEXT[k] << (8 * (KW_DEPTH - int'(KW_LEN[k])));
         if (len == LEN_W'(KW_LEN[k]) && (chars & mask) == word)
            kind = KIND_KW + KIND_W'(k);
      end
      if (overflow)
         kind = KIND_SYMBOL;
      return kind;
   endfunction

   function automatic logic [KIND_W-1:0] flush_kind(input lex_mode_type mode);
      logic [KIND_W-1:0] kind;
      case (mode)
         MODE_BANG:    kind = OP_NOT;
         MODE_AMP:     kind = OP_AND;
         MODE_PIPE:    kind = OP_OR;
         MODE_CARET:   kind = OP_XOR;
         MODE_PLUS:    kind = OP_ADD;
         MODE_MINUS:   kind = OP_SUB;
         MODE_STAR:    kind = OP_MUL;
         MODE_STAR2:   kind = OP_POW;
         MODE_SLASH:   kind = OP_DIV;
         MODE_PERCENT: kind = OP_MOD;
         MODE_EQUAL:   kind = OP_ASSIGN;
         MODE_LT:      kind = OP_LT;
         MODE_LT2:     kind = OP_SHL;
         MODE_GT:      kind = OP_GT;
         MODE_GT2:     kind = OP_SHR;
         default:      kind = OP_NE;
      endcase
      return kind;
   endfunction

endpackage
`default_nettype wire

// ===== sv/stt_req_if.sv =====
`default_nettype none
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface
`default_nettype wire

// ===== sv/stt_rsp_if.sv =====
`default_nettype none
interface stt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [stt_pkg::KIND_W-1:0]     token_kind;
   logic [stt_pkg::POS_W-1:0]      token_start;
   logic [stt_pkg::LEN_W-1:0]      token_length;
   logic [stt_pkg::ERR_W-1:0]      error_code;
   logic                           last_of_run;

   modport source (output valid, output token_kind, output token_start, output token_length,
                   output error_code, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_start, input token_length,
                 input error_code, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/source_text_tokenizer.sv =====
// a result is written to the result queue when the request that completes it is accepted
// throughput: one request per cycle if ready; each yields 0 to 2 results, one leaves per cycle
// a 4-entry result queue parts the sides; req_chan.ready drops when fewer than 2 slots are free
// reset: synchronous active high, lexer idle, offsets and length zero, queue empty
`default_nettype none
module source_text_tokenizer (
   input  wire         clock,
   input  wire         reset,
   stt_req_if.sink     req_chan,
   stt_rsp_if.source   rsp_chan
);

   localparam int QD = 4;

   stt_pkg::lex_mode_type           mode_ff, mode_in;
   logic [stt_pkg::KW_BITS-1:0]     kw_ff, kw_in;
   logic                            ovf_ff, ovf_in;
   logic [stt_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [stt_pkg::POS_W-1:0]       start_ff, start_in;
   logic [stt_pkg::POS_W-1:0]       pos_ff, pos_in;

   stt_pkg::rsp_item_type           q_ff [QD];
   logic [1:0]                      wr_ff, rd_ff;
   logic [2:0]                      cnt_ff;

   stt_pkg::rsp_item_type           e0, e1, ct, st;
   logic                            e0_v, e1_v, ct_v, st_v;
   logic                            consumed, tk_v, gr_v, accept, pop;
   logic [stt_pkg::KIND_W-1:0]      tk_kind;
   stt_pkg::lex_mode_type           gr_mode;
   logic [7:0]                      c;
   logic [stt_pkg::LEN_W-1:0]       len_inc;

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   endfunction

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = cnt_ff <= 3'(QD - 2);
   assign c = req_chan.char_code;
   assign len_inc = (len_ff == stt_pkg::LEN_MAX) ? len_ff : len_ff + 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      kw_in    = kw_ff;
      ovf_in   = ovf_ff;
      len_in   = len_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      ct = '0; ct_v = 1'b0;
      st = '0; st_v = 1'b0;
      consumed = 1'b0;
      tk_v = 1'b0; tk_kind = '0;
      gr_v = 1'b0; gr_mode = stt_pkg::MODE_IDLE;
      ct.token_start  = start_ff;
      ct.token_length = len_ff;
      ct.error_code   = stt_pkg::ERR_NONE;
      st.token_start  = pos_ff;
      st.token_length = stt_pkg::LEN_W'(1);
      st.error_code   = stt_pkg::ERR_NONE;

      if (req_chan.end_of_text) begin
         case (mode_ff)
            stt_pkg::MODE_IDLE, stt_pkg::MODE_LINE: ct_v = 1'b0;
            stt_pkg::MODE_NUMBER: begin
               ct_v = 1'b1;
               ct.token_kind = stt_pkg::KIND_NUMBER;
            end
            stt_pkg::MODE_IDENT: begin
               ct_v = 1'b1;
               ct.token_kind = stt_pkg::ident_kind(kw_ff, len_ff, ovf_ff);
            end
            stt_pkg::MODE_BLOCK, stt_pkg::MODE_BLOCK_STAR: begin
               ct_v = 1'b1;
               ct.token_kind = stt_pkg::KIND_ERROR;
               ct.error_code = stt_pkg::ERR_BLOCK;
            end
            default: begin
               ct_v = 1'b1;
               ct.token_kind = stt_pkg::flush_kind(mode_ff);
            end
         endcase
         mode_in  = stt_pkg::MODE_IDLE;
         len_in   = '0;
         start_in = '0;
         pos_in   = '0;
      end else begin
         case (mode_ff)
            stt_pkg::MODE_BANG: if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_NE; end
            stt_pkg::MODE_AMP: begin
               if (c == "&") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_ANDAND; end
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_ANDEQ; end
            end
            stt_pkg::MODE_PIPE: begin
               if (c == "|") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_OROR; end
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_OREQ; end
            end
            stt_pkg::MODE_CARET:
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_XOREQ; end
            stt_pkg::MODE_PLUS:
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_ADDEQ; end
            stt_pkg::MODE_MINUS: begin
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_SUBEQ; end
               if (c == ">") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_ARROW; end
            end
            stt_pkg::MODE_STAR: begin
               if (c == "*") begin gr_v = 1'b1; gr_mode = stt_pkg::MODE_STAR2; end
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_MULEQ; end
            end
            stt_pkg::MODE_STAR2:
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_POWEQ; end
            stt_pkg::MODE_SLASH: begin
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_DIVEQ; end
               if (c == "/") begin gr_v = 1'b1; gr_mode = stt_pkg::MODE_LINE; end
               if (c == "*") begin gr_v = 1'b1; gr_mode = stt_pkg::MODE_BLOCK; end
            end
            stt_pkg::MODE_PERCENT:
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_MODEQ; end
            stt_pkg::MODE_EQUAL:
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_EQEQ; end
            stt_pkg::MODE_LT: begin
               if (c == "<") begin gr_v = 1'b1; gr_mode = stt_pkg::MODE_LT2; end
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_LE; end
            end
            stt_pkg::MODE_LT2:
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_SHLEQ; end
            stt_pkg::MODE_GT: begin
               if (c == ">") begin gr_v = 1'b1; gr_mode = stt_pkg::MODE_GT2; end
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_GE; end
            end
            stt_pkg::MODE_GT2:
               if (c == "=") begin tk_v = 1'b1; tk_kind = stt_pkg::OP_SHREQ; end
            default: tk_v = 1'b0;
         endcase

         case (mode_ff)
            stt_pkg::MODE_IDLE: consumed = 1'b0;
            stt_pkg::MODE_NUMBER: begin
               if (is_digit(c) || is_alpha(c) || c == "." || c == "_") begin
                  consumed = 1'b1;
                  len_in = len_inc;
               end else begin
                  ct_v = 1'b1;
                  ct.token_kind = stt_pkg::KIND_NUMBER;
                  mode_in = stt_pkg::MODE_IDLE;
               end
            end
            stt_pkg::MODE_IDENT: begin
               if (is_digit(c) || is_alpha(c) || c == "_") begin
                  consumed = 1'b1;
                  if (len_ff < stt_pkg::LEN_W'(stt_pkg::KW_DEPTH))
                     kw_in[stt_pkg::KW_BITS - 1 - 8 * int'(len_ff[3:0]) -: 8] = c;
                  else
                     ovf_in = 1'b1;
                  len_in = len_inc;
               end else begin
                  ct_v = 1'b1;
                  ct.token_kind = stt_pkg::ident_kind(kw_ff, len_ff, ovf_ff);
                  mode_in = stt_pkg::MODE_IDLE;
               end
            end
            stt_pkg::MODE_LINE: begin
               consumed = 1'b1;
               len_in = len_inc;
               if (c == "\n")
                  mode_in = stt_pkg::MODE_IDLE;
            end
            stt_pkg::MODE_BLOCK: begin
               consumed = 1'b1;
               len_in = len_inc;
               if (c == "*")
                  mode_in = stt_pkg::MODE_BLOCK_STAR;
            end
            stt_pkg::MODE_BLOCK_STAR: begin
               consumed = 1'b1;
               len_in = len_inc;
               if (c == "/")
                  mode_in = stt_pkg::MODE_IDLE;
               else if (c != "*")
                  mode_in = stt_pkg::MODE_BLOCK;
            end
            default: begin
               if (tk_v) begin
                  consumed = 1'b1;
                  ct_v = 1'b1;
                  ct.token_kind = tk_kind;
                  ct.token_length = len_inc;
                  mode_in = stt_pkg::MODE_IDLE;
               end else if (gr_v) begin
                  consumed = 1'b1;
                  len_in = len_inc;
                  mode_in = gr_mode;
               end else begin
                  ct_v = 1'b1;
                  ct.token_kind = stt_pkg::flush_kind(mode_ff);
                  mode_in = stt_pkg::MODE_IDLE;
               end
            end
         endcase

         if (!consumed) begin
            case (c)
               "(", ")", "{", "}", ",", ":", ";", ".": begin
                  st_v = 1'b1;
                  case (c)
                     "(":     st.token_kind = stt_pkg::KIND_PUNCT;
                     ")":     st.token_kind = stt_pkg::KIND_PUNCT + 7'd1;
                     "{":     st.token_kind = stt_pkg::KIND_PUNCT + 7'd2;
                     "}":     st.token_kind = stt_pkg::KIND_PUNCT + 7'd3;
                     ",":     st.token_kind = stt_pkg::KIND_PUNCT + 7'd4;
                     ":":     st.token_kind = stt_pkg::KIND_PUNCT + 7'd5;
                     ";":     st.token_kind = stt_pkg::KIND_PUNCT + 7'd6;
                     default: st.token_kind = stt_pkg::KIND_PUNCT + 7'd7;
                  endcase
               end
               "~": begin
                  st_v = 1'b1;
                  st.token_kind = stt_pkg::KIND_TILDE;
               end
               "!": mode_in = stt_pkg::MODE_BANG;
               "&": mode_in = stt_pkg::MODE_AMP;
               "|": mode_in = stt_pkg::MODE_PIPE;
               "^": mode_in = stt_pkg::MODE_CARET;
               "+": mode_in = stt_pkg::MODE_PLUS;
               "-": mode_in = stt_pkg::MODE_MINUS;
               "*": mode_in = stt_pkg::MODE_STAR;
               "/": mode_in = stt_pkg::MODE_SLASH;
               "%": mode_in = stt_pkg::MODE_PERCENT;
               "=": mode_in = stt_pkg::MODE_EQUAL;
               "<": mode_in = stt_pkg::MODE_LT;
               ">": mode_in = stt_pkg::MODE_GT;
               " ", "\t", "\n": st_v = 1'b0;
               default: begin
                  if (is_digit(c)) begin
                     mode_in = stt_pkg::MODE_NUMBER;
                  end else if (is_alpha(c) || c == "_") begin
                     mode_in = stt_pkg::MODE_IDENT;
                     kw_in[stt_pkg::KW_BITS-1 -: 8] = c;
                     ovf_in = 1'b0;
                  end else begin
                     st_v = 1'b1;
                     st.token_kind = stt_pkg::KIND_ERROR;
                     st.error_code = stt_pkg::ERR_CHAR;
                  end
               end
            endcase
            if (mode_in != stt_pkg::MODE_IDLE) begin
               start_in = pos_ff;
               len_in = stt_pkg::LEN_W'(1);
            end
         end
         pos_in = pos_ff + 1'b1;
      end

      e0 = ct_v ? ct : st;
      e0_v = ct_v || st_v;
      e1 = st;
      e1_v = ct_v && st_v;
      e0.last_of_run = !e1_v;
      e1.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stt_pkg::MODE_IDLE;
         ovf_ff   <= 1'b0;
         len_ff   <= '0;
         start_ff <= '0;
         pos_ff   <= '0;
         wr_ff    <= '0;
         rd_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            ovf_ff   <= ovf_in;
            len_ff   <= len_in;
            start_ff <= start_in;
            pos_ff   <= pos_in;
         end
         wr_ff  <= wr_ff + 2'((accept && e0_v) ? 1 : 0) + 2'((accept && e1_v) ? 1 : 0);
         rd_ff  <= rd_ff + 2'(pop ? 1 : 0);
         cnt_ff <= cnt_ff + 3'((accept && e0_v) ? 1 : 0) + 3'((accept && e1_v) ? 1 : 0)
                   - 3'(pop ? 1 : 0);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kw_ff <= kw_in;
         if (e0_v)
            q_ff[wr_ff] <= e0;
         if (e1_v)
            q_ff[wr_ff + 2'd1] <= e1;
      end
   end

   assign rsp_chan.valid        = cnt_ff != 3'd0;
   assign rsp_chan.token_kind   = q_ff[rd_ff].token_kind;
   assign rsp_chan.token_start  = q_ff[rd_ff].token_start;
   assign rsp_chan.token_length = q_ff[rd_ff].token_length;
   assign rsp_chan.error_code   = q_ff[rd_ff].error_code;
   assign rsp_chan.last_of_run  = q_ff[rd_ff].last_of_run;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QD))
      else $error("result queue overrun");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.end_of_text |=> pos_ff == '0 && mode_ff == stt_pkg::MODE_IDLE)
      else $error("end marker did not clear lexer");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_chan.end_of_text |=>
         pos_ff == stt_pkg::POS_W'($past(pos_ff) + 1'b1))
      else $error("offset did not advance");

endmodule
`default_nettype wire
